### sv/bgb_pkg.sv
package bgb_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 4;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_BITMAP = 2'd2;

   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_INK_COLOUR   = 2'd2;

   localparam logic [15:0] IMAGE_SIZE_RESET = 16'd1024;

   typedef struct packed {
      logic [1:0]        kind;
      logic signed [15:0] pen_x;
      logic signed [15:0] pen_y;
      logic signed [7:0]  glyph_advance;
      logic signed [7:0]  glyph_baseline;
      logic [7:0]        glyph_height;
      logic [7:0]        glyph_width;
      logic [7:0]        bitmap_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [31:0] pixel_colour;
      logic        last_of_item;
   } rsp_type;

   // one queued byte: leftmost column, row, and the bits that survive clipping
   typedef struct packed {
      logic [15:0] col0;
      logic [15:0] row;
      logic [7:0]  mask;
   } ent_type;

   typedef struct packed {
      logic    push;
      ent_type ent;
   } push_type;

endpackage

### sv/bitmap_glyph_blitter_core.sv
// channel   ports                                  direction  moves
// request   req_valid  req_ready  req_data         in         one input word
// response  rsp_valid  rsp_ready  rsp_data         out        one pixel write word
// config    csr_write_en  csr_index  csr_wdata     in         one register write
//
// a request word is taken whenever the byte queue has room
// a bitmap byte yields up to eight pixel words, one per cycle from the back end
// while the response side accepts them; other words yield no pixel words
// the queue lets the front keep taking words while the response side stalls
// synchronous active-high reset clears pen, glyph counters, queue and output valid
module bitmap_glyph_blitter_core
   import bgb_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [15:0] image_height_ff;
   logic [15:0] image_width_ff;
   logic [31:0] ink_colour_ff;

   push_type q_push;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;
   ent_type  q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff <= IMAGE_SIZE_RESET;
         image_width_ff  <= IMAGE_SIZE_RESET;
         ink_colour_ff   <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[15:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[15:0];
            CSR_INK_COLOUR:   ink_colour_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bgb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .image_height (image_height_ff),
      .image_width  (image_width_ff),
      .q_full       (q_full),
      .q_push       (q_push)
   );

   bgb_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_head  (q_head)
   );

   bgb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .ink_colour (ink_colour_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### sv/bgb_front.sv
module bgb_front
   import bgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   input  logic [15:0] image_height,
   input  logic [15:0] image_width,
   input  logic        q_full,
   output push_type    q_push
);

   logic signed [15:0] pen_column_ff, pen_column_in;
   logic signed [15:0] baseline_row_ff, baseline_row_in;
   logic signed [15:0] glyph_left_ff, glyph_left_in;
   logic signed [16:0] glyph_top_ff, glyph_top_in;
   logic [5:0]         bytes_per_row_ff, bytes_per_row_in;
   logic [7:0]         rows_in_glyph_ff, rows_in_glyph_in;
   logic [7:0]         current_row_ff, current_row_in;
   logic [5:0]         current_byte_ff, current_byte_in;

   logic               accept;
   logic signed [17:0] row;
   logic signed [17:0] col0;
   logic signed [17:0] col;
   logic               row_ok;
   logic               byte_live;
   logic [7:0]         mask;
   logic [8:0]         width_round;
   logic signed [15:0] pen_next;
   logic [6:0]         byte_next;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign byte_live = (bytes_per_row_ff != 6'd0) && (current_row_ff < rows_in_glyph_ff);
   assign row  = 18'(glyph_top_ff) + $signed({10'd0, current_row_ff});
   assign col0 = 18'(glyph_left_ff) + $signed({9'd0, current_byte_ff, 3'd0});
   assign row_ok = !row[17] && (row[16:0] < {1'b0, image_height});

   // bit 7 is the leftmost pixel
   always_comb begin
      mask = '0;
      col  = '0;
      for (int i = 0; i < 8; i++) begin
         col = col0 + 18'(i);
         mask[7-i] = req_data.bitmap_byte[7-i] && row_ok && !col[17]
                     && (col[16:0] < {1'b0, image_width});
      end
   end

   assign width_round = {1'b0, req_data.glyph_width} + 9'd7;
   assign pen_next    = pen_column_ff + 16'(req_data.glyph_advance);
   assign byte_next   = {1'b0, current_byte_ff} + 7'd1;

   always_comb begin
      pen_column_in    = pen_column_ff;
      baseline_row_in  = baseline_row_ff;
      glyph_left_in    = glyph_left_ff;
      glyph_top_in     = glyph_top_ff;
      bytes_per_row_in = bytes_per_row_ff;
      rows_in_glyph_in = rows_in_glyph_ff;
      current_row_in   = current_row_ff;
      current_byte_in  = current_byte_ff;
      q_push.push      = 1'b0;
      q_push.ent.col0  = col0[15:0];
      q_push.ent.row   = row[15:0];
      q_push.ent.mask  = mask;
      if (accept) begin
         unique case (req_data.kind)
            KIND_START: begin
               pen_column_in    = req_data.pen_x;
               baseline_row_in  = req_data.pen_y;
               rows_in_glyph_in = '0;
               current_row_in   = '0;
               current_byte_in  = '0;
            end
            KIND_HEADER: begin
               glyph_left_in    = pen_column_ff;
               glyph_top_in     = 17'(baseline_row_ff) - 17'(req_data.glyph_baseline);
               bytes_per_row_in = width_round[8:3];
               rows_in_glyph_in = req_data.glyph_height;
               current_row_in   = '0;
               current_byte_in  = '0;
               pen_column_in    = pen_next;
            end
            KIND_BITMAP: begin
               if (byte_live) begin
                  q_push.push = (mask != 8'd0);
                  if (byte_next >= {1'b0, bytes_per_row_ff}) begin
                     current_byte_in = '0;
                     current_row_in  = current_row_ff + 8'd1;
                  end else begin
                     current_byte_in = byte_next[5:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_column_ff    <= '0;
         baseline_row_ff  <= '0;
         glyph_left_ff    <= '0;
         glyph_top_ff     <= '0;
         bytes_per_row_ff <= '0;
         rows_in_glyph_ff <= '0;
         current_row_ff   <= '0;
         current_byte_ff  <= '0;
      end else begin
         pen_column_ff    <= pen_column_in;
         baseline_row_ff  <= baseline_row_in;
         glyph_left_ff    <= glyph_left_in;
         glyph_top_ff     <= glyph_top_in;
         bytes_per_row_ff <= bytes_per_row_in;
         rows_in_glyph_ff <= rows_in_glyph_in;
         current_row_ff   <= current_row_in;
         current_byte_ff  <= current_byte_in;
      end
   end

endmodule

### sv/bgb_fifo.sv
module bgb_fifo
   import bgb_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  push_type q_push,
   output logic     q_full,
   output logic     q_empty,
   input  logic     q_pop,
   output ent_type  q_head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ent_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_push = q_push.push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.ent;
      end
   end

endmodule

### sv/bgb_back.sv
module bgb_back
   import bgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  ent_type     q_head,
   output logic        q_pop,
   input  logic [31:0] ink_colour,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   logic [7:0]  mask_ff, mask_in;
   logic [15:0] col0_ff, col0_in;
   logic [15:0] row_ff, row_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        advance;
   logic [2:0]  pick;
   logic [7:0]  rest;
   logic [7:0]  mask_after;

   assign advance = (mask_ff != 8'd0) && (!rsp_valid_ff || rsp_ready);

   // highest set bit is the leftmost pixel still pending
   always_comb begin
      pick = '0;
      for (int i = 0; i < 8; i++) begin
         if (mask_ff[i]) begin
            pick = 3'(i);
         end
      end
   end

   assign rest       = mask_ff & ~(8'd1 << pick);
   assign mask_after = advance ? rest : mask_ff;
   assign q_pop      = (mask_after == 8'd0) && !q_empty;

   always_comb begin
      mask_in = mask_after;
      col0_in = col0_ff;
      row_in  = row_ff;
      if (q_pop) begin
         mask_in = q_head.mask;
         col0_in = q_head.col0;
         row_in  = q_head.row;
      end
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.pixel_x      = col0_ff + {13'd0, 3'd7 - pick};
         rsp_data_in.pixel_y      = row_ff;
         rsp_data_in.pixel_colour = ink_colour;
         rsp_data_in.last_of_item = (rest == 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col0_ff     <= col0_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
